FILE: hdl/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg
// Shared constants, register indexes and types for the set-associative LRU
// cache tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package salru_pkg;

  // Default sizing of the tracker.
  localparam int unsigned MaxSetBitsDef = 6;
  localparam int unsigned MaxWaysDef    = 8;
  localparam int unsigned AddrWidthDef  = 64;

  // Fixed field widths of the ports.
  localparam int unsigned AddrPortW = 64;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned CntW      = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 6;
  localparam int unsigned SetCfgW   = 3;
  localparam int unsigned BlkCfgW   = 6;
  localparam int unsigned WayCfgW   = 4;
  // Effective set bit count; holds values up to 15.
  localparam int unsigned SetCntW   = 4;
  // Sum of set and block bit counts.
  localparam int unsigned ShiftW    = 7;

  // Reset values of the configuration registers.
  localparam logic [SetCfgW-1:0] SetBitsRst = 3'd4;
  localparam logic [BlkCfgW-1:0] BlkBitsRst = 6'd4;
  localparam logic [WayCfgW-1:0] WaysRst    = 4'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS       = 2'd2,
    REG_NONE       = 2'd3
  } cfg_reg_e;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  // Outcome of one set lookup.
  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_res_t;

  // Saturating add of a small increment to a running total.
  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] v,
                                              input logic [1:0] inc);
    logic [CntW:0] sum;
    sum = {1'b0, v} + {{(CntW-1){1'b0}}, inc};
    return sum[CntW] ? {CntW{1'b1}} : sum[CntW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/salru_way_logic.sv
// ----------------------------------------------------------------------------
// salru_way_logic
// Searches the ways of one set for the tag, picks the way to fill and returns
// the updated valid, tag and recency fields of the set.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_way_logic
  import salru_pkg::*;
#(
  parameter int unsigned MAX_WAYS = MaxWaysDef,
  parameter int unsigned TAG_W    = AddrWidthDef - 2,
  parameter int unsigned AGE_W    = (MaxWaysDef > 1) ? $clog2(MaxWaysDef) : 1,
  parameter int unsigned WCNT_W   = $clog2(MaxWaysDef + 1)
) (
  input  wire logic [MAX_WAYS-1:0]            valid_i,
  input  wire logic [MAX_WAYS-1:0][TAG_W-1:0] tags_i,
  input  wire logic [MAX_WAYS-1:0][AGE_W-1:0] ages_i,
  input  wire logic [TAG_W-1:0]               tag_i,
  input  wire logic [WCNT_W-1:0]              ways_i,
  output logic      [MAX_WAYS-1:0]            valid_o,
  output logic      [MAX_WAYS-1:0][TAG_W-1:0] tags_o,
  output logic      [MAX_WAYS-1:0][AGE_W-1:0] ages_o,
  output lookup_res_t                         res_o
);

  localparam int unsigned WayW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [AGE_W-1:0] AgeMax = AGE_W'(MAX_WAYS - 1);

  logic            hit_found, emp_found, lru_found;
  logic [WayW-1:0] hit_way, emp_way, lru_way, sel_way;
  logic [AGE_W-1:0] max_age, old_age;
  logic            old_inf;

  always_comb begin
    hit_found = 1'b0;
    emp_found = 1'b0;
    lru_found = 1'b0;
    hit_way   = '0;
    emp_way   = '0;
    lru_way   = '0;
    max_age   = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (WCNT_W'(j) < ways_i) begin
        if (valid_i[j]) begin
          // Strictly older wins, so the lowest way is kept among equal ages.
          if (!lru_found || (ages_i[j] > max_age)) begin
            max_age   = ages_i[j];
            lru_way   = WayW'(j);
            lru_found = 1'b1;
          end
          if (tags_i[j] == tag_i) begin
            hit_way   = WayW'(j);
            hit_found = 1'b1;
          end
        end else if (!emp_found) begin
          emp_way   = WayW'(j);
          emp_found = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (hit_found) begin
      sel_way = hit_way;
      old_age = ages_i[hit_way];
      old_inf = 1'b0;
    end else if (emp_found) begin
      sel_way = emp_way;
      old_age = '0;
      old_inf = 1'b1;
    end else begin
      sel_way = lru_way;
      old_age = ages_i[lru_way];
      old_inf = 1'b0;
    end

    valid_o = valid_i;
    tags_o  = tags_i;
    ages_o  = ages_i;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if ((WCNT_W'(j) < ways_i) && (WayW'(j) != sel_way) && valid_i[j] &&
          (old_inf || (ages_i[j] < old_age)) && (ages_i[j] < AgeMax)) begin
        ages_o[j] = ages_i[j] + AGE_W'(1);
      end
    end
    ages_o[sel_way]  = '0;
    valid_o[sel_way] = 1'b1;
    tags_o[sel_way]  = tag_i;

    res_o.hit   = hit_found;
    res_o.evict = !hit_found && !emp_found;
  end

endmodule

`default_nettype wire

FILE: hdl/set_assoc_lru_cache_tracker_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker_unit
// Tag-only set-associative cache tracker with LRU replacement and saturating
// hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// Flow: the set memory row is registered when a request is accepted, and the
// result is registered when the set is written back in the update state,
// which waits while a held result is stalled by the receiver. The next request
// waits for that write, so no two accesses to a set overlap.
// Reset: asynchronous, active low; all lines read as empty right after reset
// (per-set valid flops), totals are zero, no clearing pass is needed.
`default_nettype none

module set_assoc_lru_cache_tracker_unit
  import salru_pkg::*;
#(
  parameter int unsigned MAX_SET_BITS = MaxSetBitsDef,
  parameter int unsigned MAX_WAYS     = MaxWaysDef,
  parameter int unsigned ADDR_WIDTH   = AddrWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // Request channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [AddrPortW-1:0] address_i,
  input  wire logic [CmdW-1:0]     command_i,
  // Result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     was_hit_o,
  output logic                     was_miss_o,
  output logic                     was_eviction_o,
  output logic                     second_hit_o,
  output logic [CntW-1:0]          hit_total_o,
  output logic [CntW-1:0]          miss_total_o,
  output logic [CntW-1:0]          eviction_total_o
);

  localparam int unsigned NumSets = 1 << MAX_SET_BITS;
  localparam int unsigned TagW    = ADDR_WIDTH - 2;
  localparam int unsigned AgeW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WCntW   = $clog2(MAX_WAYS + 1);
  localparam int unsigned RowW    = MAX_WAYS * (1 + TagW + AgeW);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [SetCfgW-1:0] set_bits_q;
  logic [BlkCfgW-1:0] blk_bits_q;
  logic [WayCfgW-1:0] ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= SetBitsRst;
      blk_bits_q <= BlkBitsRst;
      ways_q     <= WaysRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SET_BITS:   set_bits_q <= cfg_wdata_i[SetCfgW-1:0];
        REG_BLOCK_BITS: blk_bits_q <= cfg_wdata_i[BlkCfgW-1:0];
        REG_WAYS:       ways_q     <= cfg_wdata_i[WayCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Effective configuration after clamping
  logic [SetCntW-1:0] s_eff;
  logic [BlkCfgW-1:0] b_eff;
  logic [WCntW-1:0]   ways_eff;
  logic [4:0]         ways_wide;

  always_comb begin
    if (set_bits_q == '0) begin
      s_eff = SetCntW'(1);
    end else if ({1'b0, set_bits_q} > SetCntW'(MAX_SET_BITS)) begin
      s_eff = SetCntW'(MAX_SET_BITS);
    end else begin
      s_eff = {1'b0, set_bits_q};
    end
    b_eff = (blk_bits_q == '0) ? BlkCfgW'(1) : blk_bits_q;
    if (ways_q == '0) begin
      ways_wide = 5'd1;
    end else if ({1'b0, ways_q} > 5'(MAX_WAYS)) begin
      ways_wide = 5'(MAX_WAYS);
    end else begin
      ways_wide = {1'b0, ways_q};
    end
    ways_eff = ways_wide[WCntW-1:0];
  end

  // Address split
  logic [ADDR_WIDTH-1:0]   addr_w, addr_sh_b, addr_sh_t;
  logic [ShiftW-1:0]       tag_shift;
  logic [MAX_SET_BITS-1:0] idx_mask, set_idx;
  logic [TagW-1:0]         tag_in;

  always_comb begin
    addr_w    = address_i[ADDR_WIDTH-1:0];
    addr_sh_b = addr_w >> b_eff;
    idx_mask  = ~({MAX_SET_BITS{1'b1}} << s_eff);
    set_idx   = addr_sh_b[MAX_SET_BITS-1:0] & idx_mask;
    tag_shift = ShiftW'(s_eff) + ShiftW'(b_eff);
    addr_sh_t = addr_w >> tag_shift;
    tag_in    = addr_sh_t[TagW-1:0];
  end

  logic in_fire, upd_fire;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  // Request registers
  logic [MAX_SET_BITS-1:0] set_q;
  logic [TagW-1:0]         tag_q;
  logic                    modify_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      set_q    <= set_idx;
      tag_q    <= tag_in;
      modify_q <= (cmd_e'(command_i) == CMD_MODIFY);
    end
  end

  // Set memory: one row holds valid, tag and recency of every way.
  logic [RowW-1:0] set_mem [NumSets];
  logic [RowW-1:0] rd_row_q, rd_row, wr_row;
  logic [NumSets-1:0] row_init_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_row_q <= set_mem[set_idx];
    end
    if (upd_fire) begin
      set_mem[set_q] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q <= '0;
    end else if (upd_fire) begin
      row_init_q[set_q] <= 1'b1;
    end
  end

  // A set never written since reset reads as all lines empty.
  assign rd_row = row_init_q[set_q] ? rd_row_q : '0;

  logic [MAX_WAYS-1:0]           cur_valid, nxt_valid;
  logic [MAX_WAYS-1:0][TagW-1:0] cur_tags, nxt_tags;
  logic [MAX_WAYS-1:0][AgeW-1:0] cur_ages, nxt_ages;
  lookup_res_t                   res;

  assign {cur_valid, cur_tags, cur_ages} = rd_row;
  assign wr_row = {nxt_valid, nxt_tags, nxt_ages};

  salru_way_logic #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TagW),
    .AGE_W    (AgeW),
    .WCNT_W   (WCntW)
  ) u_way_logic (
    .valid_i  (cur_valid),
    .tags_i   (cur_tags),
    .ages_i   (cur_ages),
    .tag_i    (tag_q),
    .ways_i   (ways_eff),
    .valid_o  (nxt_valid),
    .tags_o   (nxt_tags),
    .ages_o   (nxt_ages),
    .res_o    (res)
  );

  // Sequencer
  logic out_valid_q;
  assign upd_fire = (state_q == ST_UPD) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_UPD;
      ST_UPD:  if (upd_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Totals and result register
  logic [CntW-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic [1:0]      hit_inc;
  logic            hit_q, evict_q, second_q;

  assign hit_inc = {1'b0, res.hit} + {1'b0, modify_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (upd_fire) begin
        hit_cnt_q   <= sat_add(hit_cnt_q, hit_inc);
        miss_cnt_q  <= sat_add(miss_cnt_q, {1'b0, !res.hit});
        evict_cnt_q <= sat_add(evict_cnt_q, {1'b0, res.evict});
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      hit_q    <= res.hit;
      evict_q  <= res.evict;
      second_q <= modify_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign was_hit_o        = hit_q;
  assign was_miss_o       = !hit_q;
  assign was_eviction_o   = evict_q;
  assign second_hit_o     = second_q;
  assign hit_total_o      = hit_cnt_q;
  assign miss_total_o     = miss_cnt_q;
  assign eviction_total_o = evict_cnt_q;

  // Assertions
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPD))
    else $error("result appeared without a set update");

  a_evict_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire && res.evict |-> !res.hit)
    else $error("eviction reported on a hit");

  a_hit_total_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |=> hit_cnt_q >= $past(hit_cnt_q))
    else $error("hit total decreased");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_UPD) && in_stall_o)
    else $error("request accepted while a set update is pending");

endmodule

`default_nettype wire

FILE: tb/set_assoc_lru_cache_tracker_unit_tb.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker_unit_tb
// Self-checking testbench for the set-associative LRU cache tracker. A
// behavioral copy of the tag store predicts the outcome of every request.
// Directed requests cover the configuration corners. Random request streams
// with strong set and tag locality then run under several idle and stall
// patterns.
// ----------------------------------------------------------------------------

module set_assoc_lru_cache_tracker_unit_tb;
  import salru_pkg::*;

  localparam int unsigned NumSets     = 1 << MaxSetBitsDef;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PoolSize    = 12;

  typedef struct packed {
    logic            hit;
    logic            miss;
    logic            evict;
    logic            second;
    logic [CntW-1:0] hits;
    logic [CntW-1:0] misses;
    logic [CntW-1:0] evicts;
  } access_outcome_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic [AddrPortW-1:0] address_i   = '0;
  logic [CmdW-1:0]      command_i   = '0;
  logic                 out_stall_i = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic                 was_hit_o;
  logic                 was_miss_o;
  logic                 was_eviction_o;
  logic                 second_hit_o;
  logic [CntW-1:0]      hit_total_o;
  logic [CntW-1:0]      miss_total_o;
  logic [CntW-1:0]      eviction_total_o;

  // Predicted tag store and totals.
  logic            way_valid [NumSets][MaxWaysDef];
  logic [63:0]     way_tag   [NumSets][MaxWaysDef];
  int unsigned     way_age   [NumSets][MaxWaysDef];
  logic [CntW-1:0] hits_seen;
  logic [CntW-1:0] misses_seen;
  logic [CntW-1:0] evictions_seen;
  logic [SetCfgW-1:0] set_bits_reg = SetBitsRst;
  logic [BlkCfgW-1:0] blk_bits_reg = BlkBitsRst;
  logic [WayCfgW-1:0] ways_reg     = WaysRst;

  access_outcome_t pending_results [$];
  logic [63:0]     tag_pool [PoolSize];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  int error_count   = 0;

  set_assoc_lru_cache_tracker_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .address_i        (address_i),
    .command_i        (command_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .was_hit_o        (was_hit_o),
    .was_miss_o       (was_miss_o),
    .was_eviction_o   (was_eviction_o),
    .second_hit_o     (second_hit_o),
    .hit_total_o      (hit_total_o),
    .miss_total_o     (miss_total_o),
    .eviction_total_o (eviction_total_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned eff_set_bits();
    if (set_bits_reg == 0) return 1;
    if (set_bits_reg > MaxSetBitsDef) return MaxSetBitsDef;
    return 32'(set_bits_reg);
  endfunction

  function automatic int unsigned eff_block_bits();
    return (blk_bits_reg == 0) ? 1 : 32'(blk_bits_reg);
  endfunction

  function automatic int unsigned eff_ways();
    if (ways_reg == 0) return 1;
    if (ways_reg > MaxWaysDef) return MaxWaysDef;
    return 32'(ways_reg);
  endfunction

  function automatic logic [CntW-1:0] bump(logic [CntW-1:0] v);
    return (v == {CntW{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Way w becomes the youngest; valid ways younger than its old age get older.
  function automatic void refresh_ages(int unsigned set_idx, int unsigned ways,
                                       int unsigned w, int unsigned old_age);
    for (int unsigned j = 0; j < ways; j++) begin
      if (j != w && way_valid[set_idx][j] && way_age[set_idx][j] < old_age &&
          way_age[set_idx][j] < MaxWaysDef - 1)
        way_age[set_idx][j]++;
    end
    way_age[set_idx][w] = 0;
  endfunction

  function automatic access_outcome_t predict_access(logic [63:0] addr, cmd_e cmd);
    access_outcome_t r;
    int unsigned s, b, ways, set_idx, shift, w, old_age, max_age;
    logic [63:0] tag;
    int hit_way, empty_way, lru_way;
    s       = eff_set_bits();
    b       = eff_block_bits();
    ways    = eff_ways();
    set_idx = 32'((addr >> b) & ((64'd1 << s) - 1));
    shift   = s + b;
    tag     = (shift >= 64) ? 64'd0 : addr >> shift;
    hit_way   = -1;
    empty_way = -1;
    lru_way   = -1;
    max_age   = 0;
    for (int j = 0; j < ways; j++) begin
      if (way_valid[set_idx][j]) begin
        if (lru_way < 0 || way_age[set_idx][j] > max_age) begin
          max_age = way_age[set_idx][j];
          lru_way = j;
        end
        if (way_tag[set_idx][j] == tag) hit_way = j;
      end else if (empty_way < 0) begin
        empty_way = j;
      end
    end
    r = '0;
    r.second = (cmd == CMD_MODIFY);
    if (hit_way >= 0) begin
      r.hit = 1'b1;
      hits_seen = bump(hits_seen);
      refresh_ages(set_idx, ways, hit_way, way_age[set_idx][hit_way]);
    end else begin
      r.miss = 1'b1;
      misses_seen = bump(misses_seen);
      if (empty_way >= 0) begin
        w       = empty_way;
        old_age = 32'hFFFF_FFFF;
      end else begin
        r.evict = 1'b1;
        evictions_seen = bump(evictions_seen);
        w       = lru_way;
        old_age = way_age[set_idx][w];
      end
      way_valid[set_idx][w] = 1'b1;
      way_tag[set_idx][w]   = tag;
      refresh_ages(set_idx, ways, w, old_age);
    end
    // The store half of a modify always hits the line just touched.
    if (r.second) hits_seen = bump(hits_seen);
    r.hits   = hits_seen;
    r.misses = misses_seen;
    r.evicts = evictions_seen;
    return r;
  endfunction

  task automatic send_access(logic [63:0] addr, cmd_e cmd);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    command_i  <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_access(addr, cmd));
  endtask

  // Stop offering requests and wait until every outstanding result is back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_SET_BITS:   set_bits_reg = val[SetCfgW-1:0];
      REG_BLOCK_BITS: blk_bits_reg = val[BlkCfgW-1:0];
      REG_WAYS:       ways_reg     = val[WayCfgW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [CfgDataW-1:0] sb, logic [CfgDataW-1:0] bb,
                           logic [CfgDataW-1:0] wb);
    settle();
    write_reg(REG_SET_BITS, sb);
    write_reg(REG_BLOCK_BITS, bb);
    write_reg(REG_WAYS, wb);
  endtask

  // Random request aimed at a few hot sets and a small pool of tags, so that
  // hits, fills and evictions all happen often.
  task automatic send_random_access();
    int unsigned s, b, ways, set_idx, hot_sets, pick;
    logic [63:0] addr, tag, offset;
    cmd_e cmd;
    s        = eff_set_bits();
    b        = eff_block_bits();
    ways     = eff_ways();
    hot_sets = ((1 << s) < 4) ? (1 << s) : 4;
    pick     = $urandom_range(99);
    if (pick < 10) begin
      addr = {$urandom(), $urandom()};
    end else begin
      set_idx = ($urandom_range(4) == 0) ? $urandom_range((1 << s) - 1)
                                         : $urandom_range(hot_sets - 1);
      tag     = tag_pool[$urandom_range(ways + 2)];
      offset  = {$urandom(), $urandom()} & ((64'd1 << b) - 1);
      addr    = (tag << (s + b)) | (64'(set_idx) << b) | offset;
    end
    pick = $urandom_range(15);
    if (pick < 5) cmd = CMD_LOAD;
    else if (pick < 10) cmd = CMD_STORE;
    else if (pick < 15) cmd = CMD_MODIFY;
    else cmd = CMD_RSVD;
    send_access(addr, cmd);
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    access_outcome_t want, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{was_hit_o, was_miss_o, was_eviction_o, second_hit_o,
              hit_total_o, miss_total_o, eviction_total_o};
      if (pending_results.size() == 0) begin
        if (error_count < 10) $display("ERROR: result with no request outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (error_count < 10)
            $display({"ERROR: mismatch\n  expected hit=%0b miss=%0b evict=%0b ",
                      "second=%0b totals %0d/%0d/%0d\n  actual   hit=%0b miss=%0b ",
                      "evict=%0b second=%0b totals %0d/%0d/%0d"},
                     want.hit, want.miss, want.evict, want.second,
                     want.hits, want.misses, want.evicts,
                     got.hit, got.miss, got.evict, got.second,
                     got.hits, got.misses, got.evicts);
          error_count++;
        end
      end
    end
  end

  // Default geometry: 16 sets, 16-byte lines, direct mapped.
  task automatic test_reset_config();
    send_access(64'h0, CMD_LOAD);
    send_access(64'hF, CMD_STORE);
    send_access(64'h0, CMD_MODIFY);
    // The reserved command behaves as a load; this one conflicts in set 0.
    send_access(64'h100, CMD_RSVD);
    send_access(64'hFFFF_FFFF_FFFF_FFFF, CMD_LOAD);
    send_access(64'hFFFF_FFFF_FFFF_FFF0, CMD_STORE);
    send_access(64'h7FFF_FFFF_FFFF_FFF0, CMD_LOAD);
  endtask

  task automatic test_config_extremes();
    // Zero in every register is clamped to one.
    configure(6'd0, 6'd0, 6'd0);
    send_access(64'h2, CMD_LOAD);
    send_access(64'h6, CMD_MODIFY);
    // Largest values: set and ways are clamped, the tag shifts out to zero.
    configure(6'd7, 6'd63, 6'd15);
    send_access(64'h8000_0000_0000_0000, CMD_LOAD);
    send_access(64'h0, CMD_LOAD);
    send_access(64'hFFFF_FFFF_FFFF_FFFF, CMD_STORE);
    settle();
    write_reg(REG_NONE, 6'h3F);
    configure(6'd3, 6'd40, 6'd8);
    send_access(64'h1234_5678_9ABC_DEF0, CMD_LOAD);
  endtask

  // Lines survive a change of associativity, which can leave the same tag in
  // two ways of one set; the higher way must then win.
  task automatic test_way_resize();
    configure(6'd1, 6'd1, 6'd8);
    for (int t = 1; t <= 9; t++) send_access(64'(t) << 2, CMD_LOAD);
    configure(6'd1, 6'd1, 6'd1);
    send_access(64'd3 << 2, CMD_LOAD);
    configure(6'd1, 6'd1, 6'd8);
    send_access(64'd3 << 2, CMD_MODIFY);
  endtask

  // Receiver holds off long enough that the block has to stall its input.
  task automatic test_backpressure();
    configure(6'd3, 6'd4, 6'd4);
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk_i);
    hold_left = 60;
    repeat (24) send_random_access();
  endtask

  task automatic test_random_traffic();
    int unsigned set_cfg [8]  = '{4, 1, 6, 2, 0, 7, 3, 5};
    int unsigned blk_cfg [8]  = '{4, 1, 32, 10, 0, 63, 5, 40};
    int unsigned way_cfg [8]  = '{1, 8, 8, 2, 0, 15, 4, 3};
    int          send_pct [4] = '{0, 81, 0, 11};
    int          recv_pct [4] = '{0, 0, 81, 11};
    int          c;
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 2; k++) begin
        c = 2 * p + k;
        configure(CfgDataW'(set_cfg[c]), CfgDataW'(blk_cfg[c]), CfgDataW'(way_cfg[c]));
        send_idle_pct = send_pct[p];
        stall_pct     = recv_pct[p];
        for (int i = 0; i < PoolSize; i++)
          tag_pool[i] = (i < 8) ? 64'(i) : {$urandom(), $urandom()};
        repeat (160) send_random_access();
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  initial begin
    for (int s = 0; s < NumSets; s++) begin
      for (int w = 0; w < MaxWaysDef; w++) begin
        way_valid[s][w] = 1'b0;
        way_tag[s][w]   = '0;
        way_age[s][w]   = 0;
      end
    end
    hits_seen      = '0;
    misses_seen    = '0;
    evictions_seen = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_config();
    test_config_extremes();
    test_way_resize();
    test_backpressure();
    test_random_traffic();
    settle();

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/salru_pkg.sv
hdl/salru_way_logic.sv
hdl/set_assoc_lru_cache_tracker_unit.sv
tb/set_assoc_lru_cache_tracker_unit_tb.sv
